### hdl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Shared types, command codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package sfs_pkg;

	localparam int MAX_ACROSS_DEF = 16;
	localparam int MAX_DOWN_DEF   = 16;
	localparam int TIME_BITS_DEF  = 24;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int MODE_LOOP_BIT = 0;
	localparam int MODE_PP_BIT   = 1;

	localparam logic [23:0] PERIOD_RST = 24'd65536;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_START  = 3'd1,
		CMD_STOP   = 3'd2,
		CMD_PAUSE  = 3'd3,
		CMD_RESUME = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		REG_ACROSS = 3'd0,
		REG_DOWN   = 3'd1,
		REG_WIDTH  = 3'd2,
		REG_HEIGHT = 3'd3,
		REG_FIRST  = 3'd4,
		REG_LAST   = 3'd5,
		REG_MODE   = 3'd6,
		REG_PERIOD = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CNT,
		ST_RANGE,
		ST_LEN,
		ST_ACC,
		ST_ADV,
		ST_MAP,
		ST_FRAME,
		ST_DIV,
		ST_MULX,
		ST_MULY,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [23:0] elapsed;
	} req_t;

	typedef struct packed {
		logic [7:0]  frame_index;
		logic [13:0] origin_x;
		logic [13:0] origin_y;
		logic        playing;
	} rsp_t;

endpackage

### hdl/sfs_div.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfs_div import sfs_pkg::*; #(
	parameter int NUM_W = 9,
	parameter int DEN_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != CNT_W'(1);
			done_q <= cnt_q == CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
		end
	end

	assign done = done_q;
	assign quo  = num_q;
	assign rem  = rem_q;

endmodule

### hdl/sprite_frame_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Each request steps through the states CNT, RANGE, LEN, ACC, ADV, MAP, FRAME,
//   DIV, MULX, MULY and FINISH, and the next is taken only back in IDLE; a held
//   response in the output register can hold the unit in FINISH.
// The bit-serial divide of the frame index by frames_across runs in DIV.
// A finished response waits in the output register while the next request
//   is taken. Reset stops playback, clears position and time, loads defaults.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_unit import sfs_pkg::*; #(
	parameter int MAX_ACROSS = MAX_ACROSS_DEF,
	parameter int MAX_DOWN   = MAX_DOWN_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp
);

	localparam int AW  = $clog2(MAX_ACROSS + 1);
	localparam int DW  = $clog2(MAX_DOWN + 1);
	localparam int CW  = $clog2(MAX_ACROSS * MAX_DOWN + 1);
	localparam int FW  = (CW > 8) ? CW : 8;
	localparam int NW  = FW + 1;
	localparam int LW  = FW + 2;
	localparam int AC  = TIME_BITS + 1;
	localparam int SW  = ((AC > 24) ? AC : 24) + 1;
	localparam int MW  = FW + 10;
	localparam logic [SW-1:0] TMASK = {SW{1'b1}} >> (SW - TIME_BITS);
	localparam logic [SW-1:0] AMAX  = {SW{1'b1}} >> (SW - AC);

	state_t state_q, state_d;

	logic [4:0]  across_q, down_q;
	logic [9:0]  width_q, height_q;
	logic [7:0]  first_q, last_q;
	logic [1:0]  mode_q;
	logic [23:0] period_q;

	logic [LW-1:0] pos_q;
	logic          run_q;
	logic [AC-1:0] acc_q;

	logic [2:0]    cmd_q;
	logic [23:0]   elapsed_q;
	logic [CW-1:0] count_q;
	logic [FW-1:0] s_q, e_q, f_q;
	logic          eq_q, lt_q, fwd_q;
	logic [NW-1:0] n_q;
	logic [LW-1:0] len_q, k_q;
	logic [13:0]   ox_q, oy_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic [AW-1:0] a_eff;
	logic [DW-1:0] d_eff;
	logic [FW-1:0] cnt_f, s_c, e_c;
	logic [NW-1:0] n_c;
	logic [LW-1:0] len_c, pc, k_c, t_c;
	logic          fwd_c;
	logic [FW-1:0] f_c;
	logic [SW-1:0] sum_c, sat_c;
	logic          acc_ge;
	logic [LW:0]   pos_inc;
	logic [FW-1:0] mul_a;
	logic [9:0]    mul_b;
	logic [MW-1:0] prod;
	logic          div_start;
	logic          div_done;
	logic [FW-1:0] quo;
	logic [AW-1:0] rem;
	logic          load_rsp;

	assign a_eff = (across_q == 5'd0) ? AW'(1) :
		((int'(across_q) > MAX_ACROSS) ? AW'(MAX_ACROSS) : AW'(across_q));
	assign d_eff = (down_q == 5'd0) ? DW'(1) :
		((int'(down_q) > MAX_DOWN) ? DW'(MAX_DOWN) : DW'(down_q));

	assign mul_a = (state_q == ST_CNT)  ? FW'(a_eff) :
	               (state_q == ST_MULX) ? FW'(rem)   : quo;
	assign mul_b = (state_q == ST_CNT)  ? 10'(d_eff) :
	               (state_q == ST_MULX) ? width_q    : height_q;
	assign prod  = MW'(mul_a) * MW'(mul_b);

	assign cnt_f = FW'(count_q);
	assign s_c   = (FW'(first_q) >= cnt_f) ? FW'(cnt_f - 1'b1) : FW'(first_q);
	assign e_c   = (FW'(last_q)  >= cnt_f) ? FW'(cnt_f - 1'b1) : FW'(last_q);

	always_comb begin
		if (s_q < e_q) begin
			n_c = NW'(e_q) - NW'(s_q) + NW'(1);
		end else begin
			n_c = NW'(cnt_f) - NW'(s_q) + NW'(e_q) + NW'(1);
		end
		if (s_q == e_q) begin
			len_c = LW'(1);
		end else if (s_q < e_q) begin
			len_c = mode_q[MODE_PP_BIT] ? LW'({n_c - NW'(1), 1'b0}) : LW'(n_c);
		end else begin
			len_c = mode_q[MODE_PP_BIT] ? LW'({n_c, 1'b0}) : LW'(n_c);
		end
	end

	assign sum_c  = SW'(acc_q) + (SW'(elapsed_q) & TMASK);
	assign sat_c  = (sum_c > AMAX) ? AMAX : sum_c;
	assign acc_ge = SW'(acc_q) >= SW'(period_q);
	assign pos_inc = {1'b0, pos_q} + (LW+1)'(1);

	always_comb begin
		pc    = (pos_q < len_q) ? pos_q : len_q - LW'(1);
		fwd_c = pc < LW'(n_q);
		if (fwd_c) begin
			k_c = pc;
		end else if (lt_q) begin
			k_c = pc - LW'(n_q);
		end else begin
			k_c = LW'({n_q, 1'b0}) - LW'(1) - pc;
		end
	end

	always_comb begin
		t_c = LW'(s_q) + k_q;
		if (eq_q) begin
			f_c = s_q;
		end else if (lt_q) begin
			f_c = fwd_q ? FW'(t_c) : FW'(LW'(e_q) - LW'(1) - k_q);
		end else begin
			f_c = (t_c >= LW'(cnt_f)) ? FW'(t_c - LW'(cnt_f)) : FW'(t_c);
		end
	end

	assign div_start = state_q == ST_FRAME;

	sfs_div #(
		.NUM_W(FW),
		.DEN_W(AW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (f_c),
		.den   (a_eff),
		.done  (div_done),
		.quo   (quo),
		.rem   (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		load_rsp  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) state_d = ST_CNT;
			end
			ST_CNT:   state_d = ST_RANGE;
			ST_RANGE: state_d = ST_LEN;
			ST_LEN:   state_d = ST_ACC;
			ST_ACC:   state_d = ST_ADV;
			ST_ADV:   state_d = ST_MAP;
			ST_MAP:   state_d = ST_FRAME;
			ST_FRAME: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) state_d = ST_MULX;
			end
			ST_MULX:  state_d = ST_MULY;
			ST_MULY:  state_d = ST_FINISH;
			ST_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			across_q    <= 5'd1;
			down_q      <= 5'd1;
			width_q     <= 10'd1;
			height_q    <= 10'd1;
			first_q     <= '0;
			last_q      <= '0;
			mode_q      <= '0;
			period_q    <= PERIOD_RST;
			pos_q       <= '0;
			run_q       <= 1'b0;
			acc_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_ACROSS: across_q <= cfg_data[4:0];
					REG_DOWN:   down_q   <= cfg_data[4:0];
					REG_WIDTH:  width_q  <= cfg_data[9:0];
					REG_HEIGHT: height_q <= cfg_data[9:0];
					REG_FIRST:  first_q  <= cfg_data[7:0];
					REG_LAST:   last_q   <= cfg_data[7:0];
					REG_MODE:   mode_q   <= cfg_data[1:0];
					REG_PERIOD: period_q <= cfg_data[23:0];
					default: ;
				endcase
			end
			if (state_q == ST_ACC) begin
				case (cmd_q)
					CMD_TICK: begin
						if (run_q) acc_q <= sat_c[AC-1:0];
					end
					CMD_START: begin
						pos_q <= '0;
						run_q <= !eq_q;
					end
					CMD_STOP: begin
						pos_q <= '0;
						run_q <= 1'b0;
					end
					CMD_PAUSE:  run_q <= 1'b0;
					CMD_RESUME: run_q <= 1'b1;
					default: ;
				endcase
			end
			if (state_q == ST_ADV && cmd_q == CMD_TICK && run_q && acc_ge) begin
				if (pos_inc >= {1'b0, len_q}) begin
					if (mode_q[MODE_LOOP_BIT]) begin
						pos_q <= '0;
					end else begin
						pos_q <= len_q - LW'(1);
						run_q <= 1'b0;
					end
				end else begin
					pos_q <= pos_inc[LW-1:0];
				end
				acc_q <= AC'(SW'(acc_q) - SW'(period_q));
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_q     <= req.cmd;
			elapsed_q <= req.elapsed;
		end
		if (state_q == ST_CNT) count_q <= prod[CW-1:0];
		if (state_q == ST_RANGE) begin
			s_q <= s_c;
			e_q <= e_c;
		end
		if (state_q == ST_LEN) begin
			eq_q  <= s_q == e_q;
			lt_q  <= s_q < e_q;
			n_q   <= n_c;
			len_q <= len_c;
		end
		if (state_q == ST_MAP) begin
			k_q   <= k_c;
			fwd_q <= fwd_c;
		end
		if (state_q == ST_FRAME) f_q <= f_c;
		if (state_q == ST_MULX) ox_q <= prod[13:0];
		if (state_q == ST_MULY) oy_q <= prod[13:0];
		if (load_rsp) begin
			rsp_q.frame_index <= f_q[7:0];
			rsp_q.origin_x    <= ox_q;
			rsp_q.origin_y    <= oy_q;
			rsp_q.playing     <= run_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### hdl/sfs_chk.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module sfs_chk import sfs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a transaction is in flight");

	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response appeared without a transaction in flight");

endmodule

bind sprite_frame_sequencer_unit sfs_chk u_sfs_chk (.*);

### bench/sfs_frame_checker.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer checker
// Tracks register writes and each accepted command transaction. Predicts
// the frame, origin and play flag that the unit shows after the command,
// and compares every accepted response with the oldest prediction in order.
// ----------------------------------------------------------------------------
module sfs_frame_checker import sfs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  req_t                  req,
	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  rsp_t                  rsp,
	output int                    mismatches,
	output int                    in_flight
);

	localparam longint ACC_MAX = (longint'(1) << (TIME_BITS_DEF + 1)) - 1;

	logic [4:0]  across_r, down_r;
	logic [9:0]  fw_r, fh_r;
	logic [7:0]  first_r, last_r;
	logic [1:0]  mode_r;
	logic [23:0] period_r;
	logic [8:0]  pos_r;
	logic        run_r;
	logic [24:0] acc_r;

	rsp_t shown_frames[$];
	int   cmds_taken;
	int   frames_taken;

	assign in_flight = cmds_taken - frames_taken;

	function automatic int sheet_across();
		int a;
		a = across_r;
		if (a == 0) a = 1;
		if (a > MAX_ACROSS_DEF) a = MAX_ACROSS_DEF;
		return a;
	endfunction

	function automatic int sheet_down();
		int d;
		d = down_r;
		if (d == 0) d = 1;
		if (d > MAX_DOWN_DEF) d = MAX_DOWN_DEF;
		return d;
	endfunction

	function automatic int clamp_frame(int f);
		int c;
		c = sheet_across() * sheet_down();
		return (f >= c) ? c - 1 : f;
	endfunction

	function automatic int path_len();
		int s, e, c, n;
		s = clamp_frame(first_r);
		e = clamp_frame(last_r);
		c = sheet_across() * sheet_down();
		if (s == e) return 1;
		if (s < e) return mode_r[MODE_PP_BIT] ? 2 * (e - s) : e - s + 1;
		n = c - s + e + 1;
		return mode_r[MODE_PP_BIT] ? 2 * n : n;
	endfunction

	function automatic int frame_at_pos(int p);
		int s, e, c, n, k, f;
		s = clamp_frame(first_r);
		e = clamp_frame(last_r);
		c = sheet_across() * sheet_down();
		if (s == e) return s;
		if (s < e) begin
			n = e - s + 1;
			return (p < n) ? s + p : e - 1 - (p - n);
		end
		n = c - s + e + 1;
		k = (p < n) ? p : 2 * n - 1 - p;
		f = s + k;
		if (f >= c) f -= c;
		return f;
	endfunction

	// update playback state for one command, return the frame shown after it
	function automatic rsp_t play_step(req_t item);
		int     len, p, f, a;
		longint sum;
		rsp_t   r;
		len = path_len();
		case (item.cmd)
			CMD_TICK: begin
				if (run_r) begin
					sum = longint'(acc_r) + longint'(item.elapsed);
					if (sum > ACC_MAX) sum = ACC_MAX;
					if (sum >= longint'(period_r)) begin
						if (int'(pos_r) + 1 >= len) begin
							if (mode_r[MODE_LOOP_BIT]) begin
								pos_r = '0;
							end else begin
								pos_r = 9'(len - 1);
								run_r = 1'b0;
							end
						end else begin
							pos_r = pos_r + 1'b1;
						end
						sum = sum - longint'(period_r);
					end
					acc_r = 25'(sum);
				end
			end
			CMD_START: begin
				pos_r = '0;
				run_r = (clamp_frame(first_r) != clamp_frame(last_r));
			end
			CMD_STOP: begin
				pos_r = '0;
				run_r = 1'b0;
			end
			CMD_PAUSE: begin
				run_r = 1'b0;
			end
			CMD_RESUME: begin
				run_r = 1'b1;
			end
			default: begin
			end
		endcase
		p = (int'(pos_r) < len) ? int'(pos_r) : len - 1;
		f = frame_at_pos(p);
		a = sheet_across();
		r.frame_index = 8'(f);
		r.origin_x    = 14'((f % a) * int'(fw_r));
		r.origin_y    = 14'((f / a) * int'(fh_r));
		r.playing     = run_r;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("response %0d: %s", frames_taken, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			across_r     = 5'd1;
			down_r       = 5'd1;
			fw_r         = 10'd1;
			fh_r         = 10'd1;
			first_r      = '0;
			last_r       = '0;
			mode_r       = '0;
			period_r     = PERIOD_RST;
			pos_r        = '0;
			run_r        = 1'b0;
			acc_r        = '0;
			mismatches   = 0;
			cmds_taken   <= 0;
			frames_taken <= 0;
			shown_frames.delete();
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_ACROSS: across_r = cfg_data[4:0];
					REG_DOWN:   down_r   = cfg_data[4:0];
					REG_WIDTH:  fw_r     = cfg_data[9:0];
					REG_HEIGHT: fh_r     = cfg_data[9:0];
					REG_FIRST:  first_r  = cfg_data[7:0];
					REG_LAST:   last_r   = cfg_data[7:0];
					REG_MODE:   mode_r   = cfg_data[1:0];
					REG_PERIOD: period_r = cfg_data[23:0];
					default: begin
					end
				endcase
			end
			if (req_valid && req_ready) begin
				shown_frames.insert(shown_frames.size(), play_step(req));
				cmds_taken <= cmds_taken + 1;
			end
			if (rsp_valid && rsp_ready) begin
				frames_taken <= frames_taken + 1;
				if (shown_frames.size() == 0) begin
					report_mismatch($sformatf("unexpected response frame %0d",
						rsp.frame_index));
				end else begin
					want = shown_frames.pop_front();
					if (rsp.frame_index !== want.frame_index)
						report_mismatch($sformatf("frame_index %0d, want %0d",
							rsp.frame_index, want.frame_index));
					if (rsp.origin_x !== want.origin_x)
						report_mismatch($sformatf("origin_x %0d, want %0d",
							rsp.origin_x, want.origin_x));
					if (rsp.origin_y !== want.origin_y)
						report_mismatch($sformatf("origin_y %0d, want %0d",
							rsp.origin_y, want.origin_y));
					if (rsp.playing !== want.playing)
						report_mismatch($sformatf("playing %0b, want %0b",
							rsp.playing, want.playing));
				end
			end
		end
	end

endmodule

### bench/tb_sprite_frame_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Sprite frame sequencer testbench
// Drives command transactions over a series of sheet setups, from short
// directed runs through random play, pause and stop traffic with random
// idle gaps on both channels; the checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_sprite_frame_sequencer_unit;
	import sfs_pkg::*;

	localparam logic [2:0] CMD_BAD_FIRST = 3'd5;
	localparam logic [2:0] CMD_BAD_LAST  = 3'd7;

	localparam logic [1:0] MODE_ONCE    = 2'b00;
	localparam logic [1:0] MODE_LOOP    = 2'(1 << MODE_LOOP_BIT);
	localparam logic [1:0] MODE_PP_ONCE = 2'(1 << MODE_PP_BIT);
	localparam logic [1:0] MODE_PP_LOOP = MODE_LOOP | MODE_PP_ONCE;

	localparam int PHASES     = 12;
	localparam int PHASE_CMDS = 78;
	localparam int SETTLE     = 24;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_ready;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_ready;
	rsp_t                  rsp;
	int                    mismatches;
	int                    in_flight;

	bit          req_calm = 1'b0;
	bit          rsp_calm = 1'b0;
	logic [23:0] sheet_period = PERIOD_RST;

	always #4 clk = ~clk;

	sprite_frame_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	sfs_frame_checker mon (.*);

	function automatic int idle_cycles(bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_cmd(logic [2:0] code, logic [23:0] elapsed_in);
		int gap;
		req_valid <= 1'b1;
		req       <= '{cmd: code, elapsed: elapsed_in};
		do @(posedge clk); while (!req_ready);
		gap = idle_cycles(req_calm);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid, wait for every response, then let the unit settle
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [23:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic load_sheet(int across, int down, int fw, int fh, int first, int last,
			logic [1:0] mode, logic [23:0] period);
		write_reg(REG_ACROSS, 24'(across));
		write_reg(REG_DOWN, 24'(down));
		write_reg(REG_WIDTH, 24'(fw));
		write_reg(REG_HEIGHT, 24'(fh));
		write_reg(REG_FIRST, 24'(first));
		write_reg(REG_LAST, 24'(last));
		write_reg(REG_MODE, 24'(mode));
		write_reg(REG_PERIOD, period);
		cfg_we <= 1'b0;
		sheet_period = period;
	endtask

	function automatic int pick_span(int lo_cap, int hi_cap);
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, hi_cap) : $urandom_range(0, lo_cap);
	endfunction

	function automatic logic [23:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 24'($urandom_range(1, 131072));
		if (r < 60) return 24'($urandom_range(0, 16));
		if (r < 80) return 24'($urandom);
		return PERIOD_RST;
	endfunction

	function automatic logic [23:0] pick_elapsed();
		int r, span;
		span = (sheet_period == 0) ? 255 : int'(sheet_period) * 2;
		if (span > 24'hFFFFFF) span = 24'hFFFFFF;
		r = $urandom_range(0, 99);
		if (r < 50) return 24'($urandom_range(0, span));
		if (r < 70) return 24'($urandom);
		if (r < 80) return 24'hFFFFFF;
		if (r < 88) return '0;
		return sheet_period;
	endfunction

	task automatic play_phase();
		int i, r;
		logic [2:0] code;
		if ($urandom_range(0, 3) != 0)
			send_cmd(CMD_START, 24'($urandom));
		for (i = 0; i < PHASE_CMDS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 5) code = CMD_START;
			else if (r < 8) code = CMD_STOP;
			else if (r < 12) code = CMD_PAUSE;
			else if (r < 17) code = CMD_RESUME;
			else if (r < 20) code = 3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
			else code = CMD_TICK;
			send_cmd(code, pick_elapsed());
		end
	endtask

	initial begin
		int n;
		rsp_ready <= 1'b0;
		@(posedge clk);
		forever begin
			n = idle_cycles(rsp_calm);
			if (n == 0) begin
				rsp_ready <= 1'b1;
				@(posedge clk);
			end else begin
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		#(8 * 800000);
		$display("FAIL");
		$finish;
	end

	initial begin
		int ph, n;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_ACROSS;
		cfg_data  <= '0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-frame sheet at reset defaults
		send_cmd(CMD_TICK, '0);
		send_cmd(CMD_START, 24'hFFFFFF);
		send_cmd(CMD_RESUME, '0);
		send_cmd(CMD_TICK, 24'hFFFFFF);
		send_cmd(CMD_TICK, 24'h000001);
		for (n = CMD_BAD_FIRST; n <= CMD_BAD_LAST; n++)
			send_cmd(3'(n), 24'($urandom));
		send_cmd(CMD_PAUSE, '0);
		send_cmd(CMD_STOP, '0);
		drain();

		// full sheet, zero period, saturate the accumulator
		load_sheet(16, 16, 1023, 1023, 0, 255, MODE_PP_LOOP, '0);
		send_cmd(CMD_START, '0);
		send_cmd(CMD_TICK, '0);
		send_cmd(CMD_TICK, 24'hFFFFFF);
		send_cmd(CMD_TICK, 24'hFFFFFF);
		send_cmd(CMD_TICK, 24'hFFFFFF);
		send_cmd(CMD_PAUSE, '0);
		send_cmd(CMD_TICK, 24'hFFFFFF);
		send_cmd(CMD_RESUME, '0);
		send_cmd(CMD_TICK, 24'h000001);
		drain();

		// shrink the range under a held position
		load_sheet(5, 5, 7, 9, 3, 4, MODE_ONCE, '0);
		send_cmd(CMD_RESUME, '0);
		send_cmd(CMD_TICK, 24'h000010);
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			req_calm = ($urandom_range(0, 3) == 0);
			rsp_calm = ($urandom_range(0, 3) == 0);
			case (ph)
				0: load_sheet(4, 3, 100, 50, 10, 2, MODE_PP_LOOP, 24'd65536);
				1: load_sheet(0, 31, 1, 1, 200, 7, MODE_PP_ONCE, 24'hFFFFFF);
				2: load_sheet(16, 16, 1023, 1023, 0, 255, MODE_LOOP, 24'd1);
				3: load_sheet(1, 1, 1, 1, 0, 0, MODE_ONCE, PERIOD_RST);
				4: load_sheet(6, 5, 37, 513, 7, 21, MODE_PP_ONCE, 24'd4096);
				5: load_sheet(31, 1, 1023, 1, 255, 0, MODE_PP_LOOP, '0);
				default: load_sheet(pick_span(9, 31), pick_span(9, 31),
					$urandom_range(1, 1023), $urandom_range(1, 1023),
					pick_span(40, 255), pick_span(40, 255),
					2'($urandom_range(0, 3)), pick_period());
			endcase
			play_phase();
			drain();
		end

		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
